FILE: rtl/move_to_front_token_decoder_assert.svh
// Assertion macros used by the move-to-front token decoder controller.
`ifndef MOVE_TO_FRONT_TOKEN_DECODER_ASSERT_SVH
`define MOVE_TO_FRONT_TOKEN_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while in reset.
`define MTF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while in reset.
`define MTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front token decoder package
// Shared widths, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mtf_pkg;

   localparam int DEFAULT_LIST_DEPTH = 128;
   localparam int SYM_W              = 8;
   localparam int IDX_IN_W           = 7;

   localparam logic OP_LITERAL = 1'b0;
   localparam logic OP_INDEX   = 1'b1;

   typedef struct packed {
      logic capture;
      logic commit;
   } mtf_cmd_type;

   typedef struct packed {
      logic out_full;
   } mtf_sts_type;

endpackage

FILE: rtl/mtf_ctrl.sv
`timescale 1ns / 1ps
`include "move_to_front_token_decoder_assert.svh"
// ----------------------------------------------------------------------------
// Move-to-front decoder controller
// Sequences capture of one item and the list update that follows it.
// ----------------------------------------------------------------------------
module mtf_ctrl
   import mtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mtf_sts_type status,
   output mtf_cmd_type cmd
);

   typedef enum logic [0:0] {
      ST_READY,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   always_comb begin
      cmd.capture = req_valid && req_ready_ff;
      cmd.commit  = (state_ff == ST_UPDATE) && !status.out_full;
      state_in    = state_ff;
      case (state_ff)
         ST_READY: begin
            if (cmd.capture) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (cmd.commit) state_in = ST_READY;
         end
         default: state_in = ST_READY;
      endcase
      req_ready_in = (state_in == ST_READY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

   `MTF_ASSERT_NEXT(a_accept_to_update, clock, reset, cmd.capture, state_ff == ST_UPDATE && !req_ready_ff, "item accepted but no update follows")
   `MTF_ASSERT_NOW(a_commit_slot_free, clock, reset, cmd.commit, !status.out_full, "commit while result slot is occupied")
   `MTF_ASSERT_NEXT(a_commit_to_ready, clock, reset, cmd.commit, state_ff == ST_READY && req_ready_ff, "controller not ready after commit")
   `MTF_ASSERT_NEXT(a_stall_holds, clock, reset, state_ff == ST_UPDATE && status.out_full, state_ff == ST_UPDATE, "update left while result stalled")

endmodule

FILE: rtl/mtf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front decoder datapath
// Recency list cells with parallel match-and-shift, symbol and result registers.
// ----------------------------------------------------------------------------
module mtf_datapath
   import mtf_pkg::*;
#(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
)
(
   input  logic                clock,
   input  logic                reset,
   input  mtf_cmd_type         cmd,
   output mtf_sts_type         status,
   input  logic                req_op,
   input  logic [SYM_W-1:0]    req_literal_byte,
   input  logic [IDX_IN_W-1:0] req_list_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SYM_W-1:0]    rsp_symbol
);

   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [SYM_W-1:0]      list_ff [LIST_DEPTH];
   logic [SYM_W-1:0]      sym_ff, sym_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]      rsp_symbol_ff, rsp_symbol_in;
   logic [8:0]            idx_ext;
   logic                  in_range;
   logic [ADDR_W-1:0]     rd_addr;
   logic [LIST_DEPTH-1:0] hit;
   logic [LIST_DEPTH-1:1] shift_en;
   logic [LIST_DEPTH-1:0] lower_mask;

   // select symbol for the incoming item
   always_comb begin
      idx_ext  = 9'(req_list_index);
      in_range = idx_ext < 9'(LIST_DEPTH);
      rd_addr  = idx_ext[ADDR_W-1:0];
      sym_in   = sym_ff;
      if (cmd.capture) begin
         if (req_op == OP_LITERAL) sym_in = req_literal_byte;
         else if (in_range)        sym_in = list_ff[rd_addr];
         else                      sym_in = '0;
      end
   end

   // a cell shifts when no cell nearer the head holds the symbol
   always_comb begin
      lower_mask = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         hit[k] = (list_ff[k] == sym_ff);
      end
      for (int k = 1; k < LIST_DEPTH; k++) begin
         lower_mask  = (LIST_DEPTH'(1) << k) - LIST_DEPTH'(1);
         shift_en[k] = ~|(hit & lower_mask);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = sym_ff;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LIST_DEPTH; k++) list_ff[k] <= '0;
      end else if (cmd.commit) begin
         list_ff[0] <= sym_ff;
         for (int k = 1; k < LIST_DEPTH; k++) begin
            if (shift_en[k]) list_ff[k] <= list_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   assign status.out_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;

endmodule

FILE: rtl/move_to_front_token_decoder.sv
`timescale 1ns / 1ps
// Each accepted item's symbol is registered; its result is offered once the
// list update commits, and no new item is taken before that, as set by the
// match-and-shift pass over the recency list cells after each accepted item.
// A result that waits on rsp_ready holds the next list update.
// Reset: synchronous; clears every list cell to zero and drops any result.
// ----------------------------------------------------------------------------
// Move-to-front token decoder
// Decodes literal and list index tokens into bytes, keeping a recency list.
// ----------------------------------------------------------------------------
module move_to_front_token_decoder
   import mtf_pkg::*;
#(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [SYM_W-1:0]    req_literal_byte,
   input  logic [IDX_IN_W-1:0] req_list_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SYM_W-1:0]    rsp_symbol
);

   mtf_cmd_type cmd;
   mtf_sts_type status;

   mtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mtf_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_literal_byte (req_literal_byte),
      .req_list_index   (req_list_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol)
   );

endmodule

FILE: tb/tb_move_to_front_token_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front token decoder testbench
// Drives literal and list index tokens in bursts against a stalling receiver.
// A scoreboard keeps its own recency list and checks every decoded symbol.
// ----------------------------------------------------------------------------

class symbol_tracker;

   localparam int DEPTH = mtf_pkg::DEFAULT_LIST_DEPTH;

   bit [mtf_pkg::SYM_W-1:0] recency[DEPTH];
   bit [mtf_pkg::SYM_W-1:0] expected_symbols[$];
   int                      mismatches;

   function int pending();
      return expected_symbols.size();
   endfunction

   function bit [mtf_pkg::SYM_W-1:0] decode_token(input logic op,
                                                 input logic [mtf_pkg::SYM_W-1:0] lit,
                                                 input logic [mtf_pkg::IDX_IN_W-1:0] idx);
      bit [mtf_pkg::SYM_W-1:0] sym;
      int                      pos;
      if (op == mtf_pkg::OP_LITERAL) begin
         sym = lit;
      end else if (int'(idx) < DEPTH) begin
         sym = recency[idx];
      end else begin
         sym = '0;
      end
      pos = DEPTH - 1;
      for (int k = 0; k < DEPTH; k++) begin
         if (recency[k] == sym) begin
            pos = k;
            break;
         end
      end
      for (int k = pos; k > 0; k--) begin
         recency[k] = recency[k-1];
      end
      recency[0] = sym;
      return sym;
   endfunction

   function void note_token(input logic op,
                            input logic [mtf_pkg::SYM_W-1:0] lit,
                            input logic [mtf_pkg::IDX_IN_W-1:0] idx);
      expected_symbols.push_back(decode_token(op, lit, idx));
   endfunction

   function void check_symbol(input logic [mtf_pkg::SYM_W-1:0] sym);
      bit [mtf_pkg::SYM_W-1:0] want;
      if (expected_symbols.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected symbol %02h with nothing pending", sym);
         end
         return;
      end
      want = expected_symbols.pop_front();
      if (sym !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("symbol mismatch: expected %02h, got %02h", want, sym);
         end
      end
   endfunction

endclass

module tb_move_to_front_token_decoder;
   import mtf_pkg::*;

   localparam int TOKEN_COUNT = 1600;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [SYM_W-1:0]    req_literal_byte;
   logic [IDX_IN_W-1:0] req_list_index;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SYM_W-1:0]    rsp_symbol;

   symbol_tracker       sb;
   int                  stall_mode;
   int                  stall_cycle;

   move_to_front_token_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_literal_byte (req_literal_byte),
      .req_list_index   (req_list_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("tb_move_to_front_token_decoder NOT OK");
      $finish;
   end

   // receiver: periodically pick a new stall style at random
   initial begin
      stall_mode  = 0;
      stall_cycle = 0;
   end

   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 50 == 49) begin
         stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= $urandom_range(0, 1);
         end
         2: begin
            rsp_ready <= (stall_cycle % 4 == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_token(req_op, req_literal_byte, req_list_index);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_symbol(rsp_symbol);
         end
      end
   end

   task automatic send_token(input logic op, input logic [SYM_W-1:0] lit,
                             input logic [IDX_IN_W-1:0] idx);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_literal_byte <= lit;
      req_list_index   <= idx;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic hold_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_symbols();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // mostly recent positions and a small alphabet so that hits are common
   task automatic send_random_token();
      logic [SYM_W-1:0]    lit;
      logic [IDX_IN_W-1:0] idx;
      int                  pick;
      lit  = $urandom_range(0, 255);
      idx  = $urandom_range(0, 127);
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) begin
         if (pick < 6) begin
            lit = $urandom_range(0, 11);
         end
         send_token(OP_LITERAL, lit, idx);
      end else begin
         if (pick < 7) begin
            idx = $urandom_range(0, 7);
         end else if (pick < 9) begin
            idx = $urandom_range(0, 31);
         end
         send_token(OP_INDEX, lit, idx);
      end
   endtask

   initial begin
      int sent;
      int burst;
      sb               = new;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= OP_LITERAL;
      req_literal_byte <= '0;
      req_list_index   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unfilled positions, field extremes, unused fields, repeated bytes
      send_token(OP_INDEX,   8'h00, 7'd0);
      send_token(OP_INDEX,   8'hFF, 7'd127);
      send_token(OP_LITERAL, 8'hFF, 7'd127);
      send_token(OP_LITERAL, 8'h00, 7'd0);
      send_token(OP_LITERAL, 8'hA5, 7'h55);
      send_token(OP_LITERAL, 8'h5A, 7'h2A);
      send_token(OP_INDEX,   8'h12, 7'd1);
      send_token(OP_INDEX,   8'h34, 7'd0);
      send_token(OP_LITERAL, 8'hFF, 7'd3);
      send_token(OP_INDEX,   8'hAA, 7'd3);
      send_token(OP_INDEX,   8'h55, 7'd4);
      send_token(OP_LITERAL, 8'h00, 7'd64);
      send_token(OP_INDEX,   8'h00, 7'd126);
      send_token(OP_LITERAL, 8'h7F, 7'd0);
      send_token(OP_LITERAL, 8'h80, 7'd127);
      send_token(OP_INDEX,   8'hFF, 7'd2);
      drain_symbols();

      sent = 0;
      while (sent < TOKEN_COUNT) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_random_token();
            sent++;
            if (sent == TOKEN_COUNT / 2) begin
               drain_symbols();
            end
         end
         if ($urandom_range(0, 2) != 0) begin
            hold_sender($urandom_range(1, 6));
         end
      end

      drain_symbols();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_move_to_front_token_decoder OK");
      end else begin
         $display("tb_move_to_front_token_decoder NOT OK");
      end
      $finish;
   end

endmodule

FILE: move_to_front_token_decoder.f
+incdir+rtl
rtl/mtf_pkg.sv
rtl/mtf_ctrl.sv
rtl/mtf_datapath.sv
rtl/move_to_front_token_decoder.sv
tb/tb_move_to_front_token_decoder.sv
